/* sv/ows_pkg.sv */
// Package for the 1-Wire ROM search core: request and status codes,
// item, result and search state types, and the direction lookup helper.
// No dependencies.
package ows_pkg;

   // Address length of one ROM search pass
   localparam int ROM_BITS   = 64;
   localparam int ADDR_W     = 64;
   localparam int ADDR_IDX_W = $clog2(ADDR_W);
   localparam int POS_W      = 7;

   localparam logic [ADDR_W-1:0] ADDR_MASK =
      (ROM_BITS >= ADDR_W) ? {ADDR_W{1'b1}}
                           : ((ADDR_W'(1) << ROM_BITS) - ADDR_W'(1));

   // Request kinds carried in req_tuser
   typedef enum logic [1:0] {
      REQ_RESET   = 2'd0,
      REQ_START   = 2'd1,
      REQ_TRIPLET = 2'd2
   } req_kind_type;

   // Result status carried in rsp_tuser
   typedef enum logic [2:0] {
      ST_RESET_DONE  = 3'd0,
      ST_RUNNING     = 3'd1,
      ST_FOUND       = 3'd2,
      ST_EXHAUSTED   = 3'd3,
      ST_NO_PRESENCE = 3'd4,
      ST_BUS_ERROR   = 3'd5,
      ST_IDLE        = 3'd6
   } status_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic       presence;
      logic       id_bit;
      logic       comp_bit;
      logic       taken_dir;
   } item_type;

   typedef struct packed {
      logic [2:0]        status;
      logic              next_dir;
      logic [POS_W-1:0]  bit_number;
      logic [ADDR_W-1:0] rom_address;
   } result_type;

   typedef struct packed {
      logic [ADDR_W-1:0] search_addr;
      logic [POS_W-1:0]  last_discrep;
      logic              exhausted_flag;
      logic              pass_active;
      logic [POS_W-1:0]  bit_counter;
      logic [POS_W-1:0]  last_zero_pos;
   } state_type;

   localparam state_type STATE_RESET = '{
      search_addr:    '0,
      last_discrep:   '0,
      exhausted_flag: 1'b0,
      pass_active:    1'b0,
      bit_counter:    POS_W'(1),
      last_zero_pos:  '0
   };

   // Direction for a bit: stored bit below the last discrepancy, 1 at it, 0 above
   function automatic logic dir_for(input logic [ADDR_W-1:0] addr,
                                    input logic [POS_W-1:0]  last_d,
                                    input logic [POS_W-1:0]  pos);
      logic [POS_W-1:0] pos_m1;
      pos_m1 = pos - POS_W'(1);
      if (pos < last_d)
         return addr[pos_m1[ADDR_IDX_W-1:0]];
      return (pos == last_d);
   endfunction

endpackage

/* sv/ows_step.sv */
// Next-state and result logic for one search item.
// Depends on ows_pkg.
module ows_step (
   input  ows_pkg::state_type  cur,
   input  ows_pkg::item_type   item,
   output ows_pkg::state_type  nxt,
   output ows_pkg::result_type res
);
   import ows_pkg::*;

   logic [POS_W-1:0]  pos;
   logic [POS_W-1:0]  pos_m1;
   logic [ADDR_W-1:0] addr_upd;

   // Bit being resolved, forced to 1 when the counter is out of range
   always_comb begin
      if (cur.bit_counter < POS_W'(1) || cur.bit_counter > POS_W'(ROM_BITS)) begin
         pos = POS_W'(1);
      end else begin
         pos = cur.bit_counter;
      end
      pos_m1 = pos - POS_W'(1);
   end

   // Address with the taken direction written at the current bit
   always_comb begin
      addr_upd = cur.search_addr;
      addr_upd[pos_m1[ADDR_IDX_W-1:0]] = item.taken_dir;
      addr_upd = addr_upd & ADDR_MASK;
   end

   // Per-request state update and answer
   always_comb begin
      nxt             = cur;
      res.status      = ST_IDLE;
      res.next_dir    = 1'b0;
      res.rom_address = '0;
      case (item.req_type)
         REQ_RESET: begin
            nxt        = STATE_RESET;
            res.status = ST_RESET_DONE;
         end
         REQ_START: begin
            nxt.pass_active = 1'b0;
            nxt.bit_counter = POS_W'(1);
            if (cur.exhausted_flag) begin
               res.status = ST_EXHAUSTED;
            end else if (!item.presence) begin
               res.status = ST_NO_PRESENCE;
            end else begin
               nxt.pass_active   = 1'b1;
               nxt.last_zero_pos = '0;
               res.status        = ST_RUNNING;
               res.next_dir      = dir_for(cur.search_addr, cur.last_discrep,
                                           POS_W'(1));
            end
         end
         REQ_TRIPLET: begin
            if (!cur.pass_active) begin
               res.status = ST_IDLE;
            end else if (item.id_bit && item.comp_bit) begin
               // no device answered either value
               nxt.pass_active = 1'b0;
               nxt.bit_counter = POS_W'(1);
               res.status      = ST_BUS_ERROR;
            end else begin
               // zero-branch taken at a discrepancy
               if (!item.id_bit && !item.comp_bit && !item.taken_dir) begin
                  nxt.last_zero_pos = pos;
               end
               nxt.search_addr = addr_upd;
               if (pos >= POS_W'(ROM_BITS)) begin
                  nxt.last_discrep = nxt.last_zero_pos;
                  if (nxt.last_zero_pos == '0) begin
                     nxt.exhausted_flag = 1'b1;
                  end
                  nxt.pass_active = 1'b0;
                  nxt.bit_counter = POS_W'(1);
                  res.status      = ST_FOUND;
                  res.rom_address = addr_upd;
               end else begin
                  nxt.bit_counter = pos + POS_W'(1);
                  res.status      = ST_RUNNING;
                  res.next_dir    = dir_for(addr_upd, cur.last_discrep,
                                            pos + POS_W'(1));
               end
            end
         end
         default: begin
            res.status = ST_IDLE;
         end
      endcase
      res.bit_number = nxt.bit_counter;
   end

endmodule

/* sv/one_wire_rom_search_core.sv */
// Top level of the 1-Wire ROM search core: input register, search state,
// result register and stream handshakes. Depends on ows_pkg and ows_step.
//
//  channel | dir | tuser            | tdata
//  --------+-----+------------------+---------------------------------------
//  req     | in  | [1:0] req_type   | [0] presence [1] id_bit [2] comp_bit
//          |     |                  | [3] taken_dir [7:4] zero
//  rsp     | out | [2:0] status     | [0] next_dir [7:1] bit_number
//          |     |                  | [71:8] rom_address
//
// One item per clock sustained while rsp is not stalled; an item passes the
// input register, then the result register. The rate is set by the state
// update loop from state_ff through ows_step. Synchronous reset clears the
// search state and both valid flags; no clearing pass is needed. A stalled
// rsp holds its result while one more item waits in the input register.
module one_wire_rom_search_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // presence, id_bit, comp_bit, taken_dir, pad
   input  logic [1:0]  req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // next_dir, bit_number, rom_address
   output logic [2:0]  rsp_tuser    // status
);
   import ows_pkg::*;

   item_type   in_ff;
   item_type   in_in;
   logic       in_valid_ff;
   logic       in_valid_in;
   state_type  state_ff;
   state_type  state_in;
   result_type rsp_ff;
   result_type rsp_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   state_type  step_state;
   result_type step_res;
   logic       advance;

   // Move the held item to the result register when that is free
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   ows_step u_step (
      .cur  (state_ff),
      .item (in_ff),
      .nxt  (step_state),
      .res  (step_res)
   );

   // Next values for the pipeline registers
   always_comb begin
      in_in       = in_ff;
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_in.req_type  = req_tuser;
         in_in.presence  = req_tdata[0];
         in_in.id_bit    = req_tdata[1];
         in_in.comp_bit  = req_tdata[2];
         in_in.taken_dir = req_tdata[3];
         in_valid_in     = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      state_in     = advance ? step_state : state_ff;
      rsp_in       = advance ? step_res : rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {rsp_ff.rom_address, rsp_ff.bit_number, rsp_ff.next_dir};

`ifndef SYNTHESIS
   // An open pass always points at a bit inside the address
   a_pass_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff.pass_active |-> (state_ff.bit_counter >= POS_W'(1) &&
                                state_ff.bit_counter <= POS_W'(ROM_BITS)))
      else $error("bit counter out of range during pass");

   // With no pass open the counter rests at the first bit
   a_idle_pos: assert property (@(posedge clock) disable iff (reset)
      !state_ff.pass_active |-> state_ff.bit_counter == POS_W'(1))
      else $error("bit counter not at first bit while idle");

   // Direction only accompanies a running answer
   a_dir_running: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ST_RUNNING) |-> !rsp_tdata[0])
      else $error("next_dir set outside running status");

   // Address only accompanies a found answer
   a_addr_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ST_FOUND) |-> rsp_tdata[71:8] == '0)
      else $error("rom_address set outside found status");
`endif

endmodule

/* verif/one_wire_rom_search_core_test.sv */
// Self-checking testbench for one_wire_rom_search_core: directed rows, then simulated
// buses of several devices searched pass by pass, checked against an in-bench predictor.
// Depends on ows_pkg and the RTL of the core only.
module one_wire_rom_search_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ows_pkg::*;

   // request code the block must ignore
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      status_type  status;
      logic        next_dir;
      logic [6:0]  bit_number;
      logic [63:0] rom_address;
   } search_rsp_type;

   typedef struct {
      logic [1:0]     kind;
      logic           pres;
      logic           idb;
      logic           cmp;
      logic           dir;
      int             reps;
      bit             typed;
      search_rsp_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // presence, id_bit, comp_bit, taken_dir, pad
   logic [1:0]  req_tuser = '0;   // req_type
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;       // next_dir, bit_number, rom_address
   logic [2:0]  rsp_tuser;       // status

   // predictor copy of the search state
   logic [63:0] srch_addr = '0;
   logic [6:0]  last_fork = '0;
   logic        exhausted = 1'b0;
   logic        pass_open = 1'b0;
   logic [6:0]  bit_pos   = 7'd1;
   logic [6:0]  zero_fork = '0;

   search_rsp_type due_results[$];
   stim_row_type   directed_rows[$];
   logic           dir_hint = 1'b0;
   bit             req_calm = 1'b0;
   bit             rsp_calm = 1'b0;
   int             errors = 0;
   int             busy_items = 0;

   one_wire_rom_search_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // direction to ask for at a bit: stored bit below the fork, 1 at it, 0 above
   function automatic logic wanted_dir(input logic [6:0] pos);
      logic [6:0] pos_m1;
      pos_m1 = pos - 7'd1;
      if (pos < last_fork)
         return srch_addr[pos_m1[5:0]];
      return pos == last_fork;
   endfunction

   // advance the predicted search state by one item and return its result
   function automatic search_rsp_type search_step(input logic [1:0] kind, input logic pres,
                                                  input logic idb, input logic cmp,
                                                  input logic dir);
      search_rsp_type r;
      logic [6:0]     pos;
      logic [6:0]     pos_m1;
      r = '0;
      r.status = ST_IDLE;
      case (kind)
         REQ_RESET: begin
            srch_addr = '0;
            last_fork = '0;
            exhausted = 1'b0;
            pass_open = 1'b0;
            bit_pos   = 7'd1;
            zero_fork = '0;
            r.status  = ST_RESET_DONE;
         end
         REQ_START: begin
            pass_open = 1'b0;
            bit_pos   = 7'd1;
            if (exhausted)
               r.status = ST_EXHAUSTED;
            else if (!pres)
               r.status = ST_NO_PRESENCE;
            else begin
               pass_open  = 1'b1;
               zero_fork  = '0;
               r.status   = ST_RUNNING;
               r.next_dir = wanted_dir(7'd1);
            end
         end
         REQ_TRIPLET: begin
            if (pass_open) begin
               pos    = bit_pos;
               pos_m1 = pos - 7'd1;
               if (idb && cmp) begin
                  pass_open = 1'b0;
                  bit_pos   = 7'd1;
                  r.status  = ST_BUS_ERROR;
               end else begin
                  if (!idb && !cmp && !dir)
                     zero_fork = pos;
                  srch_addr[pos_m1[5:0]] = dir;
                  if (pos >= ROM_BITS) begin
                     last_fork = zero_fork;
                     if (zero_fork == 0)
                        exhausted = 1'b1;
                     pass_open     = 1'b0;
                     bit_pos       = 7'd1;
                     r.status      = ST_FOUND;
                     r.rom_address = srch_addr;
                  end else begin
                     bit_pos    = pos + 7'd1;
                     r.status   = ST_RUNNING;
                     r.next_dir = wanted_dir(bit_pos);
                  end
               end
            end
         end
         default: r.status = ST_IDLE;
      endcase
      r.bit_number = bit_pos;
      return r;
   endfunction

   // mostly back to back, sometimes a short pause, rarely a long pause
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   // one request transfer; the expectation is queued when it is accepted
   task automatic send(input logic [1:0] kind, input logic pres, input logic idb,
                       input logic cmp, input logic dir, input bit typed,
                       input search_rsp_type want);
      int             gap;
      search_rsp_type r;
      gap = req_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = {4'b0000, dir, cmp, idb, pres};
      do @(posedge clock); while (!req_tready);
      r = search_step(kind, pres, idb, cmp, dir);
      due_results.push_back(typed ? want : r);
      if (r.status == ST_RUNNING)
         dir_hint = r.next_dir;
      if (r.status != ST_IDLE)
         busy_items++;
      if ($urandom_range(0, 199) == 0)
         req_calm = !req_calm;
      @(negedge clock);
   endtask

   // a bus of devices whose addresses share prefixes, searched to the end
   task automatic search_bus();
      logic [63:0] roms[$];
      bit          alive[$];
      logic [63:0] mask;
      logic        idb;
      logic        cmp;
      logic        dir;
      int          n;
      int          p;
      int          passes;
      int          noise;
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 4);
      roms.push_back({$urandom, $urandom});
      for (int k = 1; k < n; k++) begin
         if ($urandom_range(0, 3) == 0)
            p = $urandom_range(0, 1) ? 0 : ROM_BITS - 1;
         else
            p = $urandom_range(0, ROM_BITS - 1);
         mask          = {$urandom, $urandom} & (~64'd0 << p);
         mask[6'(p)]   = 1'b1;
         roms.push_back(roms[$urandom_range(0, k - 1)] ^ mask);
      end
      if ($urandom_range(0, 9) != 0)
         send(REQ_RESET, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
              1'b0, '0);
      passes = 0;
      while (!exhausted && passes < n + 2) begin
         passes++;
         send(REQ_START, $urandom_range(0, 15) != 0, 1'($urandom), 1'($urandom),
              1'($urandom), 1'b0, '0);
         alive.delete();
         foreach (roms[k])
            alive.push_back(1'b1);
         for (int b = 0; b < ROM_BITS && pass_open; b++) begin
            noise = $urandom_range(0, 199);
            if (noise == 0) begin
               // restart in the middle of a pass
               send(REQ_START, 1'b1, 1'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
               foreach (alive[k])
                  alive[k] = 1'b1;
               b = -1;
            end else begin
               if (noise == 1)
                  send(REQ_UNUSED, 1'($urandom), 1'($urandom), 1'($urandom),
                       1'($urandom), 1'b0, '0);
               // wired-AND of the true and the complement bits of live devices
               idb = 1'b1;
               cmp = 1'b1;
               foreach (alive[k])
                  if (alive[k]) begin
                     idb &= roms[k][6'(b)];
                     cmp &= ~roms[k][6'(b)];
                  end
               if (noise == 2) begin
                  idb = 1'b1;
                  cmp = 1'b1;
               end
               dir = (idb == cmp) ? dir_hint : idb;
               if (noise == 3)
                  dir = 1'($urandom);
               send(REQ_TRIPLET, 1'($urandom), idb, cmp, dir, 1'b0, '0);
               foreach (alive[k])
                  alive[k] = alive[k] && (roms[k][6'(b)] == dir);
            end
         end
      end
      if (exhausted || $urandom_range(0, 3) == 0)
         send(REQ_START, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
              1'b0, '0);
   endtask

   // result side: random stalls with calm stretches
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = 1'b1;
            if (!rsp_calm && $urandom_range(0, 99) < 25)
               stall_left = pick_gap();
         end
         if ($urandom_range(0, 299) == 0)
            rsp_calm = !rsp_calm;
      end
   end

   // compare every result transfer with the oldest expectation
   always @(posedge clock) begin
      search_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_results.size() == 0) begin
            $display("%0t: result with none expected, status %0d", $time, rsp_tuser);
            errors++;
         end else begin
            want = due_results.pop_front();
            if (rsp_tuser !== want.status) begin
               $display("%0t: status expected %0d got %0d", $time, want.status, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[0] !== want.next_dir) begin
               $display("%0t: next_dir expected %0d got %0d", $time, want.next_dir,
                        rsp_tdata[0]);
               errors++;
            end
            if (rsp_tdata[7:1] !== want.bit_number) begin
               $display("%0t: bit_number expected %0d got %0d", $time, want.bit_number,
                        rsp_tdata[7:1]);
               errors++;
            end
            if (rsp_tdata[71:8] !== want.rom_address) begin
               $display("%0t: rom_address expected %h got %h", $time, want.rom_address,
                        rsp_tdata[71:8]);
               errors++;
            end
         end
      end
   end

   // run limit
   initial begin
      #3000000;
      $display("TB_ERROR");
      $finish;
   end

   // stimulus
   initial begin
      // kind, presence, id, comp, taken, repeats, typed, expected
      directed_rows = '{
         '{REQ_TRIPLET, 1'b0, 1'b1, 1'b0, 1'b1, 1,  1'b1, '{ST_IDLE, 1'b0, 7'd1, 64'd0}},
         '{REQ_UNUSED,  1'b1, 1'b1, 1'b1, 1'b1, 1,  1'b1, '{ST_IDLE, 1'b0, 7'd1, 64'd0}},
         '{REQ_START,   1'b0, 1'b0, 1'b0, 1'b0, 1,  1'b1,
           '{ST_NO_PRESENCE, 1'b0, 7'd1, 64'd0}},
         '{REQ_START,   1'b1, 1'b0, 1'b0, 1'b0, 1,  1'b1,
           '{ST_RUNNING, 1'b0, 7'd1, 64'd0}},
         '{REQ_TRIPLET, 1'b1, 1'b1, 1'b1, 1'b1, 1,  1'b1,
           '{ST_BUS_ERROR, 1'b0, 7'd1, 64'd0}},
         '{REQ_START,   1'b1, 1'b1, 1'b1, 1'b1, 1,  1'b1,
           '{ST_RUNNING, 1'b0, 7'd1, 64'd0}},
         '{REQ_TRIPLET, 1'b0, 1'b0, 1'b0, 1'b0, 1,  1'b0, '0},
         '{REQ_TRIPLET, 1'b0, 1'b1, 1'b0, 1'b1, 1,  1'b0, '0},
         '{REQ_UNUSED,  1'b0, 1'b0, 1'b0, 1'b0, 1,  1'b0, '0},
         '{REQ_START,   1'b1, 1'b0, 1'b0, 1'b0, 1,  1'b1,
           '{ST_RUNNING, 1'b0, 7'd1, 64'd0}},
         // all ones with no fork: found, then exhausted
         '{REQ_TRIPLET, 1'b1, 1'b1, 1'b0, 1'b1, 63, 1'b0, '0},
         '{REQ_TRIPLET, 1'b1, 1'b1, 1'b0, 1'b1, 1,  1'b1,
           '{ST_FOUND, 1'b0, 7'd1, ~64'd0}},
         '{REQ_START,   1'b1, 1'b0, 1'b0, 1'b0, 1,  1'b1,
           '{ST_EXHAUSTED, 1'b0, 7'd1, 64'd0}},
         '{REQ_START,   1'b0, 1'b0, 1'b0, 1'b0, 1,  1'b1,
           '{ST_EXHAUSTED, 1'b0, 7'd1, 64'd0}},
         '{REQ_TRIPLET, 1'b0, 1'b0, 1'b1, 1'b0, 1,  1'b1, '{ST_IDLE, 1'b0, 7'd1, 64'd0}},
         '{REQ_RESET,   1'b1, 1'b1, 1'b1, 1'b1, 1,  1'b1,
           '{ST_RESET_DONE, 1'b0, 7'd1, 64'd0}},
         // all zeros with a zero-branch fork at the last bit
         '{REQ_START,   1'b1, 1'b0, 1'b0, 1'b0, 1,  1'b1,
           '{ST_RUNNING, 1'b0, 7'd1, 64'd0}},
         '{REQ_TRIPLET, 1'b0, 1'b0, 1'b1, 1'b0, 63, 1'b0, '0},
         '{REQ_TRIPLET, 1'b0, 1'b0, 1'b0, 1'b0, 1,  1'b1,
           '{ST_FOUND, 1'b0, 7'd1, 64'd0}},
         // second pass takes the one branch at the last bit
         '{REQ_START,   1'b1, 1'b0, 1'b0, 1'b0, 1,  1'b0, '0},
         '{REQ_TRIPLET, 1'b1, 1'b0, 1'b1, 1'b0, 62, 1'b0, '0},
         '{REQ_TRIPLET, 1'b0, 1'b0, 1'b1, 1'b0, 1,  1'b0, '0},
         '{REQ_TRIPLET, 1'b0, 1'b0, 1'b0, 1'b1, 1,  1'b0, '0},
         '{REQ_START,   1'b1, 1'b0, 1'b0, 1'b0, 1,  1'b1,
           '{ST_EXHAUSTED, 1'b0, 7'd1, 64'd0}},
         '{REQ_RESET,   1'b0, 1'b0, 1'b0, 1'b0, 1,  1'b1,
           '{ST_RESET_DONE, 1'b0, 7'd1, 64'd0}}
      };
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         repeat (directed_rows[i].reps)
            send(directed_rows[i].kind, directed_rows[i].pres, directed_rows[i].idb,
                 directed_rows[i].cmp, directed_rows[i].dir, directed_rows[i].typed,
                 directed_rows[i].want);

      // random part: mostly whole searches, some loose noise items
      while (busy_items < 1750) begin
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4))
               send(2'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                    1'($urandom), 1'b0, '0);
         else
            search_bus();
      end

      req_tvalid = 1'b0;
      while (due_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
